>>> hw/rtl/ggn_pkg.sv
// Shared types, constants and helper functions for the gene network event engine.
// No dependencies; used by the interfaces, the divider and the top-level engine.
package ggn_pkg;

  localparam int CW         = 16;               // molecule count width
  localparam int TFB        = 24;               // fraction bits of simulated time
  localparam int NUM_RX     = 14;
  localparam int RX_W       = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int DIV_NW     = 72;               // divider numerator / quotient width
  localparam int DIV_DW     = 64;               // divider denominator width
  localparam int DIV_CNT_W  = $clog2(DIV_NW);
  localparam int NUM_LIN    = 10;
  localparam int LIN_W      = $clog2(NUM_LIN);

  localparam logic [CW-1:0] CNT_MAX    = {CW{1'b1}};
  localparam logic [CW-1:0] FREE_RESET = (500 < (2 ** CW - 1)) ? CW'(500) : CNT_MAX;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASAL_K    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INDUCED_K  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REPRESSED  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IVL = CFG_IDX_W'(3);

  localparam logic [31:0] BASAL_K_RESET   = 32'd4110;
  localparam logic [31:0] INDUCED_K_RESET = 32'd805306368;
  localparam logic [31:0] REPRESSED_RESET = 32'd6442451;
  localparam logic [15:0] SAMPLE_RESET    = 16'd10;

  // reaction codes
  localparam logic [RX_W-1:0] RX_TK_TX     = 4'd0;
  localparam logic [RX_W-1:0] RX_K_TL      = 4'd1;
  localparam logic [RX_W-1:0] RX_TS_TX     = 4'd2;
  localparam logic [RX_W-1:0] RX_S_TL      = 4'd3;
  localparam logic [RX_W-1:0] RX_TK_DEG    = 4'd4;
  localparam logic [RX_W-1:0] RX_K_DEG     = 4'd5;
  localparam logic [RX_W-1:0] RX_TS_DEG    = 4'd6;
  localparam logic [RX_W-1:0] RX_S_DEG     = 4'd7;
  localparam logic [RX_W-1:0] RX_K_BIND    = 4'd8;
  localparam logic [RX_W-1:0] RX_K_UNBIND  = 4'd9;
  localparam logic [RX_W-1:0] RX_K_ADEG    = 4'd10;
  localparam logic [RX_W-1:0] RX_S_BIND    = 4'd11;
  localparam logic [RX_W-1:0] RX_S_UNBIND  = 4'd12;
  localparam logic [RX_W-1:0] RX_S_ADEG    = 4'd13;
  localparam logic [RX_W-1:0] RX_NONE      = 4'd0;  // reported on a failed pick
  localparam logic [RX_W-1:0] RX_LAST      = RX_S_ADEG;

  // rate constants, Q0.32
  localparam logic [31:0] RATE_K_BIND = 32'd8676;
  localparam logic [31:0] RATE_S_BIND = 32'd19327;

  // reactions whose propensity is one rate times one count
  localparam logic [RX_W-1:0] LIN_RX [NUM_LIN] = '{
    RX_K_TL, RX_S_TL, RX_TK_DEG, RX_K_DEG, RX_TS_DEG,
    RX_S_DEG, RX_K_UNBIND, RX_K_ADEG, RX_S_UNBIND, RX_S_ADEG
  };
  localparam logic [31:0] LIN_RATE [NUM_LIN] = '{
    32'd3435974, 32'd42949673, 32'd21474836, 32'd429497, 32'd21474836,
    32'd429497, 32'd8590, 32'd858993, 32'd10737, 32'd8590
  };

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
    return (c == CNT_MAX) ? c : c + CW'(1);
  endfunction

  function automatic logic [CW-1:0] cnt_dec(input logic [CW-1:0] c);
    return (c == '0) ? c : c - CW'(1);
  endfunction

endpackage

>>> hw/rtl/ggn_if.sv
// Valid/ready channel interfaces of the gene network event engine.
// Depends on ggn_pkg for the count and index widths.
interface ggn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rand_time;
  logic [31:0] rand_pick;
  modport source (output valid, rand_time, rand_pick, input ready);
  modport sink   (input valid, rand_time, rand_pick, output ready);
endinterface

interface ggn_out_if;
  logic                    valid;
  logic                    ready;
  logic [63:0]             event_time;
  logic [ggn_pkg::CW-1:0]  count_k;
  logic [ggn_pkg::CW-1:0]  count_s;
  logic [ggn_pkg::RX_W-1:0] reaction;
  logic                    sampled;
  logic                    pick_error;
  modport source (output valid, event_time, count_k, count_s, reaction, sampled, pick_error,
                  input ready);
  modport sink   (input valid, event_time, count_k, count_s, reaction, sampled, pick_error,
                  output ready);
endinterface

interface ggn_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ggn_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ggn_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing; the product is valid the cycle after an enabled request.
module ggn_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/ggn_div.sv
// Restoring divider, one quotient bit per cycle, 72-bit numerator over 64-bit divisor.
// Depends on ggn_pkg for the request and response structs.
module ggn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ggn_pkg::div_req_t req_i,
  output ggn_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ggn_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ggn_pkg::DIV_DW-1:0]    rem_q, rem_d;
  logic [ggn_pkg::DIV_NW-1:0]    quo_q, quo_d;
  logic [ggn_pkg::DIV_DW-1:0]    den_q, den_d;
  logic [ggn_pkg::DIV_DW:0]      rem_sh;
  logic                          ge;

  assign rem_sh = {rem_q, quo_q[ggn_pkg::DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? ggn_pkg::DIV_DW'(rem_sh - {1'b0, den_q}) : rem_sh[ggn_pkg::DIV_DW-1:0];
      quo_d = {quo_q[ggn_pkg::DIV_NW-2:0], ge};
      cnt_d = cnt_q + ggn_pkg::DIV_CNT_W'(1);
      if (cnt_q == ggn_pkg::DIV_CNT_W'(ggn_pkg::DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quo_q;
  assign rsp_o.rem_nz = rem_q != '0;

endmodule

>>> hw/rtl/gillespie_gene_network_step.sv
// Gene network event engine: one direct-method stochastic simulation step per request.
// Requests are handled one at a time; the time taken is dominated by three divisions on the
// shared divider (two Hill terms and the time step) and 32 squaring steps of the logarithm on
// the shared multiplier, the time step and logarithm being skipped when every propensity is
// zero; it varies with the normalize shift and the reaction search over the 14 reactions. A
// finished result waits in the output register while the next request is taken.
// Uses ggn_pkg, ggn_if, ggn_mul, ggn_div.
module gillespie_gene_network_step (
  input logic      clk_i,
  input logic      rst_ni,
  ggn_in_if.sink   in_i,
  ggn_out_if.source out_o,
  ggn_cfg_if.sink  cfg_i
);

  localparam int NUM_ST = 35;

  typedef enum logic [NUM_ST-1:0] {
    ST_IDLE    = NUM_ST'(1) << 0,
    ST_HK_SQ   = NUM_ST'(1) << 1,
    ST_HK_DIV  = NUM_ST'(1) << 2,
    ST_HK_WAIT = NUM_ST'(1) << 3,
    ST_P0_MUL  = NUM_ST'(1) << 4,
    ST_P0_WR   = NUM_ST'(1) << 5,
    ST_SM_LO   = NUM_ST'(1) << 6,
    ST_SM_HI   = NUM_ST'(1) << 7,
    ST_SM_FIN  = NUM_ST'(1) << 8,
    ST_HS_DIV  = NUM_ST'(1) << 9,
    ST_HS_WAIT = NUM_ST'(1) << 10,
    ST_P2_MUL  = NUM_ST'(1) << 11,
    ST_P2_WR   = NUM_ST'(1) << 12,
    ST_LIN_MUL = NUM_ST'(1) << 13,
    ST_LIN_WR  = NUM_ST'(1) << 14,
    ST_P8_MUL  = NUM_ST'(1) << 15,
    ST_P8_SET  = NUM_ST'(1) << 16,
    ST_P11_MUL = NUM_ST'(1) << 17,
    ST_P11_SET = NUM_ST'(1) << 18,
    ST_SUM     = NUM_ST'(1) << 19,
    ST_ZCHK    = NUM_ST'(1) << 20,
    ST_NORM    = NUM_ST'(1) << 21,
    ST_SQ_MUL  = NUM_ST'(1) << 22,
    ST_SQ_WR   = NUM_ST'(1) << 23,
    ST_LN_HI   = NUM_ST'(1) << 24,
    ST_LN_LO   = NUM_ST'(1) << 25,
    ST_LN_WR   = NUM_ST'(1) << 26,
    ST_T_DIV   = NUM_ST'(1) << 27,
    ST_T_WAIT  = NUM_ST'(1) << 28,
    ST_THR_HI  = NUM_ST'(1) << 29,
    ST_THR_LO  = NUM_ST'(1) << 30,
    ST_THR_WR  = NUM_ST'(1) << 31,
    ST_PICK    = NUM_ST'(1) << 32,
    ST_UPD     = NUM_ST'(1) << 33,
    ST_OUT     = NUM_ST'(1) << 34
  } state_e;

  // what the saturating 64x32 multiply sequence is working for
  typedef enum logic [1:0] {
    JOB_HS  = 2'd0,
    JOB_P8  = 2'd1,
    JOB_P11 = 2'd2
  } job_e;

  localparam int CW = ggn_pkg::CW;

  state_e state_q, state_d;
  job_e   job_q, job_d;

  // configuration
  logic [31:0] basal_q, induced_q, repressed_q;
  logic [15:0] ivl_q;

  // simulation state
  logic [63:0]   sim_time_q, sim_time_d;
  logic [CW-1:0] pk_q, pk_d, ps_q, ps_d, tk_q, tk_d, ts_q, ts_d;
  logic [CW-1:0] free_q, free_d, bk_q, bk_d, bs_q, bs_d;
  logic [15:0]   phase_q, phase_d;

  // per-request working registers
  logic [31:0]               rt_q, rt_d, rp_q, rp_d;
  logic                      smp_q, smp_d;
  logic [31:0]               hk_q, hk_d;
  logic [32:0]               hs_q, hs_d;
  logic [63:0]               pw_q, pw_d, lo_q, lo_d;
  logic [2:0]                sm_cnt_q, sm_cnt_d;
  logic [ggn_pkg::LIN_W-1:0] li_q, li_d;
  logic [ggn_pkg::RX_W-1:0]  idx_q, idx_d;
  logic [63:0]               total_q, total_d, thr_q, thr_d, cum_q, cum_d, ln_q, ln_d;
  logic [31:0]               y_q, y_d, frac_q, frac_d;
  logic [4:0]                sh_q, sh_d, b_q, b_d;
  logic [ggn_pkg::RX_W-1:0]  sel_q, sel_d;
  logic                      err_q, err_d;

  // output register
  logic                      ovalid_q, ovalid_d;
  logic [63:0]               otime_q, otime_d;
  logic [CW-1:0]             ok_q, ok_d, os_q, os_d;
  logic [ggn_pkg::RX_W-1:0]  orx_q, orx_d;
  logic                      osmp_q, osmp_d, oerr_q, oerr_d;

  // propensities
  logic [63:0]              prop_q [ggn_pkg::NUM_RX];
  logic                     prop_we;
  logic [ggn_pkg::RX_W-1:0] prop_wa;
  logic [63:0]              prop_wd;
  logic [63:0]              prop_rd;

  // shared units
  logic              mul_en;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  ggn_pkg::div_req_t div_req;
  ggn_pkg::div_rsp_t div_rsp;

  // datapath helpers
  logic [CW-1:0]             sm_op;
  logic [64:0]               sm_sum;
  logic [63:0]               sm_res;
  logic [ggn_pkg::RX_W-1:0]  lin_rx;
  logic [CW-1:0]             lin_cnt;
  logic [32:0]               sq_t;
  logic [37:0]               ex;
  logic [63:0]               step;
  logic [63:0]               cum_nx;
  logic [15:0]               ivl_eff;
  logic [16:0]               phase_nx;
  logic                      in_acc;

  ggn_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ggn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  assign prop_rd = prop_q[idx_q];
  assign sm_op   = (job_q == JOB_P11) ? ps_q : pk_q;
  assign lin_rx  = ggn_pkg::LIN_RX[li_q];

  // 64x32 saturating product from two 32x32 halves
  assign sm_sum = {1'b0, mul_p[31:0], 32'd0} + {1'b0, lo_q};
  assign sm_res = ((mul_p[63:32] != '0) || sm_sum[64]) ? {64{1'b1}} : sm_sum[63:0];

  assign sq_t = mul_p[63:31];
  assign ex   = {6'(sh_q) + 6'd1, 32'd0} - {6'd0, frac_q};
  assign step = (div_rsp.quot[ggn_pkg::DIV_NW-1:64] != '0) ? {64{1'b1}} : div_rsp.quot[63:0];
  assign cum_nx = ggn_pkg::sat_add64(cum_q, prop_rd);

  assign ivl_eff  = (ivl_q == '0) ? 16'd1 : ivl_q;
  assign phase_nx = 17'(phase_q) + 17'd1;

  always_comb begin
    case (lin_rx)
      ggn_pkg::RX_K_TL, ggn_pkg::RX_TK_DEG:       lin_cnt = tk_q;
      ggn_pkg::RX_S_TL, ggn_pkg::RX_TS_DEG:       lin_cnt = ts_q;
      ggn_pkg::RX_K_DEG:                          lin_cnt = pk_q;
      ggn_pkg::RX_S_DEG:                          lin_cnt = ps_q;
      ggn_pkg::RX_K_UNBIND, ggn_pkg::RX_K_ADEG:   lin_cnt = bk_q;
      ggn_pkg::RX_S_UNBIND, ggn_pkg::RX_S_ADEG:   lin_cnt = bs_q;
      default:                                    lin_cnt = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    sim_time_d = sim_time_q;
    pk_d = pk_q; ps_d = ps_q; tk_d = tk_q; ts_d = ts_q;
    free_d = free_q; bk_d = bk_q; bs_d = bs_q;
    phase_d    = phase_q;
    rt_d = rt_q; rp_d = rp_q; smp_d = smp_q;
    hk_d = hk_q; hs_d = hs_q; pw_d = pw_q; lo_d = lo_q;
    sm_cnt_d = sm_cnt_q; li_d = li_q; idx_d = idx_q;
    total_d = total_q; thr_d = thr_q; cum_d = cum_q; ln_d = ln_q;
    y_d = y_q; frac_d = frac_q; sh_d = sh_q; b_d = b_q;
    sel_d = sel_q; err_d = err_q;
    ovalid_d = ovalid_q; otime_d = otime_q; ok_d = ok_q; os_d = os_q;
    orx_d = orx_q; osmp_d = osmp_q; oerr_d = oerr_q;
    prop_we = 1'b0;
    prop_wa = idx_q;
    prop_wd = sm_res;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rt_d    = in_i.rand_time;
          rp_d    = in_i.rand_pick;
          smp_d   = (phase_q == '0);
          state_d = ST_HK_SQ;
        end
      end
      ST_HK_SQ: begin
        mul_en  = 1'b1;
        mul_a   = 32'(pk_q);
        mul_b   = 32'(pk_q);
        state_d = ST_HK_DIV;
      end
      ST_HK_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = ggn_pkg::DIV_NW'(400) << 32;
        div_req.den   = ggn_pkg::sat_add64(mul_p, 64'd400);
        state_d       = ST_HK_WAIT;
      end
      ST_HK_WAIT: begin
        if (div_rsp.done) begin
          // K^2/(K^2+400) = 1 - ceil(400/(K^2+400))
          hk_d    = 32'(33'h1_0000_0000 - div_rsp.quot[32:0] - 33'(div_rsp.rem_nz));
          state_d = ST_P0_MUL;
        end
      end
      ST_P0_MUL: begin
        mul_en  = 1'b1;
        mul_a   = induced_q;
        mul_b   = hk_q;
        state_d = ST_P0_WR;
      end
      ST_P0_WR: begin
        prop_we  = 1'b1;
        prop_wa  = ggn_pkg::RX_TK_TX;
        prop_wd  = 64'(basal_q) + 64'(mul_p[63:32]);
        pw_d     = 64'd243;
        sm_cnt_d = '0;
        job_d    = JOB_HS;
        state_d  = ST_SM_LO;
      end
      ST_SM_LO: begin
        mul_en  = 1'b1;
        mul_a   = pw_q[31:0];
        mul_b   = 32'(sm_op);
        state_d = ST_SM_HI;
      end
      ST_SM_HI: begin
        lo_d    = mul_p;
        mul_en  = 1'b1;
        mul_a   = pw_q[63:32];
        mul_b   = 32'(sm_op);
        state_d = ST_SM_FIN;
      end
      ST_SM_FIN: begin
        pw_d = sm_res;
        case (job_q)
          JOB_HS: begin
            if (sm_cnt_q == 3'd4) begin
              state_d = ST_HS_DIV;
            end else begin
              sm_cnt_d = sm_cnt_q + 3'd1;
              state_d  = ST_SM_LO;
            end
          end
          JOB_P8: begin
            prop_we = 1'b1;
            prop_wa = ggn_pkg::RX_K_BIND;
            state_d = ST_P11_MUL;
          end
          default: begin
            prop_we = 1'b1;
            prop_wa = ggn_pkg::RX_S_BIND;
            idx_d   = '0;
            total_d = '0;
            state_d = ST_SUM;
          end
        endcase
      end
      ST_HS_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = ggn_pkg::DIV_NW'(100000) << 32;
        div_req.den   = ggn_pkg::sat_add64(pw_q, 64'd100000);
        state_d       = ST_HS_WAIT;
      end
      ST_HS_WAIT: begin
        if (div_rsp.done) begin
          hs_d    = div_rsp.quot[32:0];
          state_d = ST_P2_MUL;
        end
      end
      ST_P2_MUL: begin
        mul_en  = 1'b1;
        mul_a   = repressed_q;
        mul_b   = hs_q[31:0];
        state_d = ST_P2_WR;
      end
      ST_P2_WR: begin
        // a Hill term of exactly one passes the rate through
        prop_we = 1'b1;
        prop_wa = ggn_pkg::RX_TS_TX;
        prop_wd = hs_q[32] ? 64'(repressed_q) : 64'(mul_p[63:32]);
        li_d    = '0;
        state_d = ST_LIN_MUL;
      end
      ST_LIN_MUL: begin
        mul_en  = 1'b1;
        mul_a   = ggn_pkg::LIN_RATE[li_q];
        mul_b   = 32'(lin_cnt);
        state_d = ST_LIN_WR;
      end
      ST_LIN_WR: begin
        prop_we = 1'b1;
        prop_wa = lin_rx;
        prop_wd = mul_p;
        if (li_q == ggn_pkg::LIN_W'(ggn_pkg::NUM_LIN - 1)) begin
          state_d = ST_P8_MUL;
        end else begin
          li_d    = li_q + ggn_pkg::LIN_W'(1);
          state_d = ST_LIN_MUL;
        end
      end
      ST_P8_MUL: begin
        mul_en  = 1'b1;
        mul_a   = ggn_pkg::RATE_K_BIND;
        mul_b   = 32'(free_q);
        state_d = ST_P8_SET;
      end
      ST_P8_SET: begin
        pw_d    = mul_p;
        job_d   = JOB_P8;
        state_d = ST_SM_LO;
      end
      ST_P11_MUL: begin
        mul_en  = 1'b1;
        mul_a   = ggn_pkg::RATE_S_BIND;
        mul_b   = 32'(free_q);
        state_d = ST_P11_SET;
      end
      ST_P11_SET: begin
        pw_d    = mul_p;
        job_d   = JOB_P11;
        state_d = ST_SM_LO;
      end
      ST_SUM: begin
        total_d = ggn_pkg::sat_add64(total_q, prop_rd);
        if (idx_q == ggn_pkg::RX_LAST) begin
          state_d = ST_ZCHK;
        end else begin
          idx_d = idx_q + ggn_pkg::RX_W'(1);
        end
      end
      ST_ZCHK: begin
        if (total_q == '0) begin
          sim_time_d = {64{1'b1}};
          err_d      = 1'b1;
          sel_d      = ggn_pkg::RX_NONE;
          state_d    = ST_UPD;
        end else begin
          y_d     = (rt_q == '0) ? 32'd1 : rt_q;
          sh_d    = '0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (y_q[31]) begin
          b_d     = '0;
          frac_d  = '0;
          state_d = ST_SQ_MUL;
        end else begin
          y_d  = {y_q[30:0], 1'b0};
          sh_d = sh_q + 5'd1;
        end
      end
      ST_SQ_MUL: begin
        mul_en  = 1'b1;
        mul_a   = y_q;
        mul_b   = y_q;
        state_d = ST_SQ_WR;
      end
      ST_SQ_WR: begin
        if (sq_t[32]) begin
          y_d    = sq_t[32:1];
          frac_d = {frac_q[30:0], 1'b1};
        end else begin
          y_d    = sq_t[31:0];
          frac_d = {frac_q[30:0], 1'b0};
        end
        if (b_q == 5'd31) begin
          state_d = ST_LN_HI;
        end else begin
          b_d     = b_q + 5'd1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_LN_HI: begin
        mul_en  = 1'b1;
        mul_a   = 32'(ex[37:32]);
        mul_b   = ggn_pkg::LN2_Q32;
        state_d = ST_LN_LO;
      end
      ST_LN_LO: begin
        lo_d    = mul_p;
        mul_en  = 1'b1;
        mul_a   = ex[31:0];
        mul_b   = ggn_pkg::LN2_Q32;
        state_d = ST_LN_WR;
      end
      ST_LN_WR: begin
        ln_d    = lo_q + 64'(mul_p[63:32]);
        state_d = ST_T_DIV;
      end
      ST_T_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = ggn_pkg::DIV_NW'(ln_q) << ggn_pkg::TFB;
        div_req.den   = total_q;
        state_d       = ST_T_WAIT;
      end
      ST_T_WAIT: begin
        if (div_rsp.done) begin
          sim_time_d = ggn_pkg::sat_add64(sim_time_q, step);
          state_d    = ST_THR_HI;
        end
      end
      ST_THR_HI: begin
        mul_en  = 1'b1;
        mul_a   = rp_q;
        mul_b   = total_q[63:32];
        state_d = ST_THR_LO;
      end
      ST_THR_LO: begin
        lo_d    = mul_p;
        mul_en  = 1'b1;
        mul_a   = rp_q;
        mul_b   = total_q[31:0];
        state_d = ST_THR_WR;
      end
      ST_THR_WR: begin
        thr_d   = lo_q + 64'(mul_p[63:32]);
        idx_d   = '0;
        cum_d   = '0;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cum_d = cum_nx;
        if (thr_q < cum_nx) begin
          sel_d   = idx_q;
          err_d   = 1'b0;
          state_d = ST_UPD;
        end else if (idx_q == ggn_pkg::RX_LAST) begin
          sel_d   = ggn_pkg::RX_NONE;
          err_d   = 1'b1;
          state_d = ST_UPD;
        end else begin
          idx_d = idx_q + ggn_pkg::RX_W'(1);
        end
      end
      ST_UPD: begin
        if (!err_q) begin
          case (sel_q)
            ggn_pkg::RX_TK_TX:  tk_d = ggn_pkg::cnt_inc(tk_q);
            ggn_pkg::RX_K_TL:   pk_d = ggn_pkg::cnt_inc(pk_q);
            ggn_pkg::RX_TS_TX:  ts_d = ggn_pkg::cnt_inc(ts_q);
            ggn_pkg::RX_S_TL:   ps_d = ggn_pkg::cnt_inc(ps_q);
            ggn_pkg::RX_TK_DEG: tk_d = ggn_pkg::cnt_dec(tk_q);
            ggn_pkg::RX_K_DEG:  pk_d = ggn_pkg::cnt_dec(pk_q);
            ggn_pkg::RX_TS_DEG: ts_d = ggn_pkg::cnt_dec(ts_q);
            ggn_pkg::RX_S_DEG:  ps_d = ggn_pkg::cnt_dec(ps_q);
            ggn_pkg::RX_K_BIND: begin
              free_d = ggn_pkg::cnt_dec(free_q);
              pk_d   = ggn_pkg::cnt_dec(pk_q);
              bk_d   = ggn_pkg::cnt_inc(bk_q);
            end
            ggn_pkg::RX_K_UNBIND: begin
              free_d = ggn_pkg::cnt_inc(free_q);
              pk_d   = ggn_pkg::cnt_inc(pk_q);
              bk_d   = ggn_pkg::cnt_dec(bk_q);
            end
            ggn_pkg::RX_K_ADEG: begin
              free_d = ggn_pkg::cnt_inc(free_q);
              bk_d   = ggn_pkg::cnt_dec(bk_q);
            end
            ggn_pkg::RX_S_BIND: begin
              free_d = ggn_pkg::cnt_dec(free_q);
              ps_d   = ggn_pkg::cnt_dec(ps_q);
              bs_d   = ggn_pkg::cnt_inc(bs_q);
            end
            ggn_pkg::RX_S_UNBIND: begin
              free_d = ggn_pkg::cnt_inc(free_q);
              ps_d   = ggn_pkg::cnt_inc(ps_q);
              bs_d   = ggn_pkg::cnt_dec(bs_q);
            end
            ggn_pkg::RX_S_ADEG: begin
              free_d = ggn_pkg::cnt_inc(free_q);
              bs_d   = ggn_pkg::cnt_dec(bs_q);
            end
            default: ;
          endcase
        end
        phase_d = (phase_nx >= 17'(ivl_eff)) ? 16'd0 : phase_nx[15:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          otime_d  = sim_time_q;
          ok_d     = pk_q;
          os_d     = ps_q;
          orx_d    = err_q ? ggn_pkg::RX_NONE : sel_q;
          osmp_d   = smp_q;
          oerr_d   = err_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_HS;
      basal_q     <= ggn_pkg::BASAL_K_RESET;
      induced_q   <= ggn_pkg::INDUCED_K_RESET;
      repressed_q <= ggn_pkg::REPRESSED_RESET;
      ivl_q       <= ggn_pkg::SAMPLE_RESET;
      sim_time_q  <= '0;
      pk_q        <= CW'(1);
      ps_q        <= CW'(1);
      tk_q        <= '0;
      ts_q        <= '0;
      free_q      <= ggn_pkg::FREE_RESET;
      bk_q        <= '0;
      bs_q        <= '0;
      phase_q     <= '0;
      sm_cnt_q    <= '0;
      li_q        <= '0;
      idx_q       <= '0;
      sh_q        <= '0;
      b_q         <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      job_q      <= job_d;
      sim_time_q <= sim_time_d;
      pk_q       <= pk_d;
      ps_q       <= ps_d;
      tk_q       <= tk_d;
      ts_q       <= ts_d;
      free_q     <= free_d;
      bk_q       <= bk_d;
      bs_q       <= bs_d;
      phase_q    <= phase_d;
      sm_cnt_q   <= sm_cnt_d;
      li_q       <= li_d;
      idx_q      <= idx_d;
      sh_q       <= sh_d;
      b_q        <= b_d;
      ovalid_q   <= ovalid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          ggn_pkg::CFG_BASAL_K:    basal_q     <= cfg_i.data;
          ggn_pkg::CFG_INDUCED_K:  induced_q   <= cfg_i.data;
          ggn_pkg::CFG_REPRESSED:  repressed_q <= cfg_i.data;
          ggn_pkg::CFG_SAMPLE_IVL: ivl_q       <= cfg_i.data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rt_q    <= rt_d;
    rp_q    <= rp_d;
    smp_q   <= smp_d;
    hk_q    <= hk_d;
    hs_q    <= hs_d;
    pw_q    <= pw_d;
    lo_q    <= lo_d;
    total_q <= total_d;
    thr_q   <= thr_d;
    cum_q   <= cum_d;
    ln_q    <= ln_d;
    y_q     <= y_d;
    frac_q  <= frac_d;
    sel_q   <= sel_d;
    err_q   <= err_d;
    otime_q <= otime_d;
    ok_q    <= ok_d;
    os_q    <= os_d;
    orx_q   <= orx_d;
    osmp_q  <= osmp_d;
    oerr_q  <= oerr_d;
    if (prop_we) begin
      prop_q[prop_wa] <= prop_wd;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.event_time = otime_q;
  assign out_o.count_k    = ok_q;
  assign out_o.count_s    = os_q;
  assign out_o.reaction   = orx_q;
  assign out_o.sampled    = osmp_q;
  assign out_o.pick_error = oerr_q;

  // the divider is only started once the previous division has finished
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // a failed pick reports the neutral reaction code
  a_err_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oerr_q) |-> (orx_q == ggn_pkg::RX_NONE))
    else $error("pick error with a reaction code");

  a_rx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (orx_q <= ggn_pkg::RX_LAST))
    else $error("reaction index out of range");

  // simulated time never runs backward
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sim_time_q >= $past(sim_time_q))
    else $error("simulated time decreased");

endmodule

>>> verif/tb_gillespie_gene_network_step.sv
// Self-checking bench for the gene network event engine: drives event requests with random
// stalls, predicts each event in place and checks the output channel field by field.
// Depends on ggn_pkg, the ggn_if interfaces and the gillespie_gene_network_step RTL.
module tb_gillespie_gene_network_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q32_UNIT = 64'h1_0000_0000;
  localparam int QUIET_LIMIT = 12000;
  localparam int HOLD_CYCLES = 2000;

  typedef struct packed {
    logic [63:0]              event_time;
    logic [ggn_pkg::CW-1:0]   count_k;
    logic [ggn_pkg::CW-1:0]   count_s;
    logic [ggn_pkg::RX_W-1:0] reaction;
    logic                     sampled;
    logic                     pick_error;
  } event_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ggn_in_if  in_if();
  ggn_out_if out_if();
  ggn_cfg_if cfg_if();

  gillespie_gene_network_step u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor copy of configuration and molecule state
  logic [31:0]            m_basal, m_induced, m_repressed;
  logic [15:0]            m_interval, m_phase;
  logic [63:0]            m_time;
  logic [ggn_pkg::CW-1:0] m_pk, m_ps, m_tk, m_ts, m_free, m_bk, m_bs;

  event_rsp_t pending_events[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;

  function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? ALL_ONES : p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic [ggn_pkg::CW-1:0] bump_up(input logic [ggn_pkg::CW-1:0] c);
    return (c == ggn_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [ggn_pkg::CW-1:0] bump_down(input logic [ggn_pkg::CW-1:0] c);
    return (c == 0) ? c : c - 1'b1;
  endfunction

  function automatic logic [63:0] activation_hill(input logic [ggn_pkg::CW-1:0] kc);
    logic [63:0] den, num, q;
    den = 64'(kc) * 64'(kc) + 64'd400;
    num = 64'd400 << 32;
    q = num / den;
    if (q * den != num) q = q + 1;
    return Q32_UNIT - q;
  endfunction

  function automatic logic [63:0] repression_hill(input logic [ggn_pkg::CW-1:0] kc);
    logic [63:0] pw;
    pw = 64'd243;
    for (int e = 0; e < 5; e++) pw = mul_sat(pw, 64'(kc));
    return (64'd100000 << 32) / add_sat(64'd100000, pw);
  endfunction

  function automatic logic [63:0] wait_log(input logic [31:0] x);
    logic [63:0] y, frac, ex, lo;
    logic [31:0] sh;
    y = (x == 0) ? 64'd1 : 64'(x);
    frac = 0;
    sh = 0;
    while (y < 64'h8000_0000) begin
      y = y << 1;
      sh++;
    end
    for (int b = 0; b < 32; b++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= Q32_UNIT) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    ex = (64'(sh + 1) << 32) - frac;
    lo = {32'd0, ex[31:0]};
    return 64'(ex[63:32]) * 64'(ggn_pkg::LN2_Q32) + ((lo * 64'(ggn_pkg::LN2_Q32)) >> 32);
  endfunction

  function automatic logic [63:0] time_step(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q = num / den;
    rem = num % den;
    for (int b = 0; b < ggn_pkg::TFB; b++) begin
      if (q > (ALL_ONES >> 1)) return ALL_ONES;
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q[0] = 1'b1;
      end else begin
        rem = rem << 1;
      end
    end
    return q;
  endfunction

  task automatic predict_event(input logic [31:0] rt, input logic [31:0] rp,
                               output event_rsp_t ev);
    logic [63:0] prop [ggn_pkg::NUM_RX];
    logic [63:0] total, thr, cum, rp64;
    logic [15:0] ivl;
    logic [16:0] nxt;
    int sel;
    logic smp;
    smp = (m_phase == 0);
    prop[0] = 64'(m_basal) + ((64'(m_induced) * activation_hill(m_pk)) >> 32);
    prop[1] = 64'd3435974 * m_tk;
    prop[2] = (64'(m_repressed) * repression_hill(m_pk)) >> 32;
    prop[3] = 64'd42949673 * m_ts;
    prop[4] = 64'd21474836 * m_tk;
    prop[5] = 64'd429497 * m_pk;
    prop[6] = 64'd21474836 * m_ts;
    prop[7] = 64'd429497 * m_ps;
    prop[8] = mul_sat(64'd8676 * m_free, 64'(m_pk));
    prop[9] = 64'd8590 * m_bk;
    prop[10] = 64'd858993 * m_bk;
    prop[11] = mul_sat(64'd19327 * m_free, 64'(m_ps));
    prop[12] = 64'd10737 * m_bs;
    prop[13] = 64'd8590 * m_bs;
    total = 0;
    for (int x = 0; x < ggn_pkg::NUM_RX; x++) total = add_sat(total, prop[x]);
    sel = -1;
    if (total == 0) begin
      m_time = ALL_ONES;
    end else begin
      m_time = add_sat(m_time, time_step(wait_log(rt), total));
      rp64 = 64'(rp);
      thr = rp64 * (total >> 32) + ((rp64 * {32'd0, total[31:0]}) >> 32);
      cum = 0;
      for (int x = 0; x < ggn_pkg::NUM_RX; x++) begin
        cum = add_sat(cum, prop[x]);
        if (sel < 0 && thr < cum) sel = x;
      end
    end
    if (sel >= 0) begin
      case (ggn_pkg::RX_W'(sel))
        ggn_pkg::RX_TK_TX:    m_tk = bump_up(m_tk);
        ggn_pkg::RX_K_TL:     m_pk = bump_up(m_pk);
        ggn_pkg::RX_TS_TX:    m_ts = bump_up(m_ts);
        ggn_pkg::RX_S_TL:     m_ps = bump_up(m_ps);
        ggn_pkg::RX_TK_DEG:   m_tk = bump_down(m_tk);
        ggn_pkg::RX_K_DEG:    m_pk = bump_down(m_pk);
        ggn_pkg::RX_TS_DEG:   m_ts = bump_down(m_ts);
        ggn_pkg::RX_S_DEG:    m_ps = bump_down(m_ps);
        ggn_pkg::RX_K_BIND: begin
          m_free = bump_down(m_free); m_pk = bump_down(m_pk); m_bk = bump_up(m_bk);
        end
        ggn_pkg::RX_K_UNBIND: begin
          m_free = bump_up(m_free); m_pk = bump_up(m_pk); m_bk = bump_down(m_bk);
        end
        ggn_pkg::RX_K_ADEG: begin
          m_free = bump_up(m_free); m_bk = bump_down(m_bk);
        end
        ggn_pkg::RX_S_BIND: begin
          m_free = bump_down(m_free); m_ps = bump_down(m_ps); m_bs = bump_up(m_bs);
        end
        ggn_pkg::RX_S_UNBIND: begin
          m_free = bump_up(m_free); m_ps = bump_up(m_ps); m_bs = bump_down(m_bs);
        end
        ggn_pkg::RX_S_ADEG: begin
          m_free = bump_up(m_free); m_bs = bump_down(m_bs);
        end
        default: ;
      endcase
    end
    ivl = (m_interval == 0) ? 16'd1 : m_interval;
    nxt = 17'(m_phase) + 17'd1;
    m_phase = (nxt >= 17'(ivl)) ? 16'd0 : nxt[15:0];
    ev.event_time = m_time;
    ev.count_k    = m_pk;
    ev.count_s    = m_ps;
    ev.reaction   = (sel < 0) ? ggn_pkg::RX_NONE : ggn_pkg::RX_W'(sel);
    ev.sampled    = smp;
    ev.pick_error = (sel < 0);
  endtask

  // leaves valid high so back-to-back requests never toggle it within one step;
  // ready is sampled at the falling edge, where it holds its value up to the next rising edge
  task automatic send_event(input logic [31:0] rt, input logic [31:0] rp);
    event_rsp_t ev;
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.rand_time <= rt;
    in_if.rand_pick <= rp;
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    predict_event(rt, rp, ev);
    pending_events.push_back(ev);
  endtask

  task automatic drain_events();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ggn_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      ggn_pkg::CFG_BASAL_K:    m_basal = val;
      ggn_pkg::CFG_INDUCED_K:  m_induced = val;
      ggn_pkg::CFG_REPRESSED:  m_repressed = val;
      ggn_pkg::CFG_SAMPLE_IVL: m_interval = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_rates(input logic [31:0] b, input logic [31:0] i, input logic [31:0] r,
                           input logic [31:0] ivl);
    drain_events();
    write_reg(ggn_pkg::CFG_BASAL_K, b);
    write_reg(ggn_pkg::CFG_INDUCED_K, i);
    write_reg(ggn_pkg::CFG_REPRESSED, r);
    write_reg(ggn_pkg::CFG_SAMPLE_IVL, ivl);
  endtask

  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(15))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd1;
      2:       return 32'(1) << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_field_extremes();
    send_event(32'd1, 32'd1);
    send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(32'd0, 32'h8000_0000);
    send_event(32'h8000_0000, 32'd0);
    send_event(32'h5555_5555, 32'hAAAA_AAAA);
    send_event(32'hAAAA_AAAA, 32'h5555_5555);
    for (int i = 0; i < 8; i++) send_event(pick_fraction(), pick_fraction());
  endtask

  task automatic test_config_extremes();
    // all-ones rates, every step sampled; then zero rates, zero interval, bad indexes
    set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    for (int i = 0; i < 5; i++) send_event(pick_fraction(), pick_fraction());
    set_rates(32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 5; i++) send_event(pick_fraction(), 32'hFFFF_FFFF);
    set_rates(ggn_pkg::BASAL_K_RESET, ggn_pkg::INDUCED_K_RESET, ggn_pkg::REPRESSED_RESET,
              32'd65535);
    for (int i = ggn_pkg::CFG_SAMPLE_IVL + 1; i < (1 << ggn_pkg::CFG_IDX_W); i++)
      write_reg(ggn_pkg::CFG_IDX_W'(i), $urandom);
    for (int i = 0; i < 4; i++) send_event(pick_fraction(), pick_fraction());
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) send_event(pick_fraction(), pick_fraction());
  endtask

  task automatic test_output_backpressure();
    hold_reqs++;
    for (int i = 0; i < 12; i++) send_event($urandom, $urandom);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.rand_time <= '0;
    in_if.rand_pick <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    m_basal = ggn_pkg::BASAL_K_RESET;
    m_induced = ggn_pkg::INDUCED_K_RESET;
    m_repressed = ggn_pkg::REPRESSED_RESET;
    m_interval = ggn_pkg::SAMPLE_RESET;
    m_phase = 0;
    m_time = 0;
    m_pk = 1;
    m_ps = 1;
    m_tk = 0;
    m_ts = 0;
    m_free = ggn_pkg::FREE_RESET;
    m_bk = 0;
    m_bs = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_config_extremes();
    send_idle_pct = 18;
    recv_idle_pct = 60;
    set_rates($urandom, $urandom, $urandom, $urandom_range(65535, 1));
    test_random_traffic(320);
    send_idle_pct = 60;
    recv_idle_pct = 18;
    set_rates(ggn_pkg::BASAL_K_RESET, ggn_pkg::INDUCED_K_RESET, ggn_pkg::REPRESSED_RESET,
              $urandom_range(20, 1));
    test_random_traffic(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    set_rates($urandom, $urandom >> 2, $urandom, $urandom_range(16, 1));
    test_random_traffic(320);

    drain_events();
    repeat (500) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: valid and ready are stable from the falling edge to the accepting rising edge
  always @(negedge clk_i) begin
    event_rsp_t exp_ev;
    if (out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result, time %0h", out_if.event_time);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_if.event_time !== exp_ev.event_time) begin
          $error("event_time exp %0h got %0h", exp_ev.event_time, out_if.event_time);
          errors++;
        end
        if (out_if.count_k !== exp_ev.count_k) begin
          $error("count_k exp %0d got %0d", exp_ev.count_k, out_if.count_k);
          errors++;
        end
        if (out_if.count_s !== exp_ev.count_s) begin
          $error("count_s exp %0d got %0d", exp_ev.count_s, out_if.count_s);
          errors++;
        end
        if (out_if.reaction !== exp_ev.reaction) begin
          $error("reaction exp %0d got %0d", exp_ev.reaction, out_if.reaction);
          errors++;
        end
        if (out_if.sampled !== exp_ev.sampled) begin
          $error("sampled exp %0b got %0b", exp_ev.sampled, out_if.sampled);
          errors++;
        end
        if (out_if.pick_error !== exp_ev.pick_error) begin
          $error("pick_error exp %0b got %0b", exp_ev.pick_error, out_if.pick_error);
          errors++;
        end
      end
    end
  end

  // random ready, long hold on request
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_if.ready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  int quiet_cycles = 0;
  always @(negedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end
endmodule
